/* rtl/core/wtcm_pkg.sv */
`default_nettype none

package wtcm_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned FACE_H_W = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Binary angle landmarks: 65536 units per full turn.
  localparam logic [15:0] QUARTER_TURN       = 16'd16384;
  localparam logic [15:0] HALF_TURN          = 16'd32768;
  localparam logic [15:0] THREE_QUARTER_TURN = 16'd49152;

  // Default parameter values of the top level.
  localparam int unsigned DEF_SCREEN_ROWS = 512;
  localparam int unsigned DEF_TILE_SIZE   = 64;
  localparam int unsigned DEF_STRIP_WIDTH = 1;

  // Reset value of every face height register.
  localparam logic [FACE_H_W-1:0] FACE_H_RESET = 11'd64;

  // Texture faces; the code doubles as the index of its height register.
  typedef enum logic [1:0] {
    FACE_EAST  = 2'd0,
    FACE_WEST  = 2'd1,
    FACE_SOUTH = 2'd2,
    FACE_NORTH = 2'd3
  } face_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_EAST_FACE_HEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEST_FACE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOUTH_FACE_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORTH_FACE_HEIGHT = 2'd3;

  // One pixel request.
  typedef struct packed {
    logic [15:0] view_angle;
    logic        hit_vertical;
    logic [15:0] hit_x;
    logic [15:0] hit_y;
    logic [15:0] wall_height;
    logic [9:0]  column_index;
    logic [3:0]  sub_column;
    logic [9:0]  row;
  } in_item_t;

  // One texel coordinate result.
  typedef struct packed {
    logic [13:0] screen_x;
    logic [9:0]  screen_y;
    logic [1:0]  face;
    logic [5:0]  texel_x;
    logic [9:0]  texel_y;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/wall_texel_coordinate_mapper.sv */
`default_nettype none

// Wall texel coordinate mapper: takes one screen pixel request per clock while it is
// not stalled and, for a row inside the wall span and a sub-column inside the strip,
// returns its screen position, texture face and texel coordinates; other requests
// are taken and dropped. Throughput is one item per cycle while the output is not
// stalled. The path holds 14 register stages: a span/face stage, a multiply stage,
// eleven restoring-divide stages (one quotient bit each) for the texel row, and the
// output register. Bubbles in the pipeline are filled even while the output is
// stalled. The user must write the face height registers through the configuration
// port only while no item is in flight; the block itself does not enforce it.
module wall_texel_coordinate_mapper import wtcm_pkg::*; #(
  parameter int unsigned SCREEN_ROWS = DEF_SCREEN_ROWS,
  parameter int unsigned TILE_SIZE   = DEF_TILE_SIZE,
  parameter int unsigned STRIP_WIDTH = DEF_STRIP_WIDTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [FACE_H_W-1:0]  cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_item_o
);

  localparam int unsigned QW = FACE_H_W;
  localparam int unsigned PW = 16 + FACE_H_W;
  localparam logic [16:0] Center     = 17'(SCREEN_ROWS / 2);
  localparam logic [16:0] ScreenRows = 17'(SCREEN_ROWS);
  localparam logic [4:0]  StripW     = 5'(STRIP_WIDTH);
  localparam logic [8:0]  TileSz     = 9'(TILE_SIZE);
  localparam logic [31:0] TileRecip  = 32'((64'd1 << 32) / TILE_SIZE);

  // Fields that ride along the pipeline unchanged once formed.
  typedef struct packed {
    logic [13:0] screen_x;
    logic [9:0]  screen_y;
    face_e       face;
    logic [5:0]  texel_x;
  } side_t;

  // Face height registers.
  logic [FACE_H_W-1:0] face_rows_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        face_rows_q[i] <= FACE_H_RESET;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EAST_FACE_HEIGHT:  face_rows_q[FACE_EAST]  <= cfg_data_i;
        REG_WEST_FACE_HEIGHT:  face_rows_q[FACE_WEST]  <= cfg_data_i;
        REG_SOUTH_FACE_HEIGHT: face_rows_q[FACE_SOUTH] <= cfg_data_i;
        REG_NORTH_FACE_HEIGHT: face_rows_q[FACE_NORTH] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline registers.
  logic                s0_v_q, s1_v_q, out_v_q;
  side_t               s0_side_q, s1_side_q;
  logic [15:0]         s0_coord_q, s1_coord_q, s1_qest_q;
  logic [15:0]         s0_offset_q;
  logic [15:0]         s0_h_q, s1_h_q;
  logic [FACE_H_W-1:0] s0_fh_q, s1_fh_q;
  logic [PW-1:0]       s1_prod_q;
  out_item_t           out_q;

  logic                d_v_q    [QW];
  logic [PW-1:0]       d_rem_q  [QW];
  logic [QW-1:0]       d_quo_q  [QW];
  logic [15:0]         d_h_q    [QW];
  logic [FACE_H_W-1:0] d_fh_q   [QW];
  side_t               d_side_q [QW];

  // Per-stage advance: a stage loads when it is empty or its content moves on.
  logic          en0, en1, en_out;
  logic [QW-1:0] en_d;

  always_comb begin
    en_out = !out_v_q || !out_stall_i;
    en_d[QW-1] = !d_v_q[QW-1] || en_out;
    for (int k = QW - 2; k >= 0; k--) begin
      en_d[k] = !d_v_q[k] || en_d[k+1];
    end
    en1 = !s1_v_q || en_d[0];
    en0 = !s0_v_q || en1;
  end

  assign in_stall_o = !en0;

  // Stage 0: span test, face choice, screen position and texture coordinate source.
  logic [16:0]   row_ext, sum_top, span_end;
  logic          keep;
  face_e         face_sel;
  side_t         side_in;
  logic [14:0]   sx_full;

  always_comb begin
    row_ext  = 17'(in_item_i.row);
    sum_top  = row_ext + 17'(in_item_i.wall_height[15:1]);
    span_end = Center + 17'(in_item_i.wall_height[15:1]);
    keep = (sum_top >= Center) && (row_ext < span_end) && (row_ext < ScreenRows) &&
           (5'(in_item_i.sub_column) < StripW);
    if (in_item_i.hit_vertical) begin
      face_sel = (in_item_i.view_angle < QUARTER_TURN ||
                  in_item_i.view_angle > THREE_QUARTER_TURN) ? FACE_EAST : FACE_WEST;
    end else begin
      face_sel = (in_item_i.view_angle != 16'd0 &&
                  in_item_i.view_angle < HALF_TURN) ? FACE_SOUTH : FACE_NORTH;
    end
    sx_full = 15'(in_item_i.column_index) * 15'(STRIP_WIDTH) + 15'(in_item_i.sub_column);
    side_in.screen_x = sx_full[13:0];
    side_in.screen_y = in_item_i.row;
    side_in.face     = face_sel;
    side_in.texel_x  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en0) begin
      s0_v_q <= in_valid_i && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i && keep) begin
      s0_side_q   <= side_in;
      s0_coord_q  <= in_item_i.hit_vertical ? in_item_i.hit_y : in_item_i.hit_x;
      s0_offset_q <= 16'(sum_top - Center);
      s0_h_q      <= in_item_i.wall_height;
      s0_fh_q     <= face_rows_q[face_sel];
    end
  end

  // Stage 1: scale the row offset by the face height; estimate coord / tile size.
  logic [47:0] coord_recip;

  assign coord_recip = 48'(s0_coord_q) * 48'(TileRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en1) begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s0_v_q) begin
      s1_side_q  <= s0_side_q;
      s1_coord_q <= s0_coord_q;
      s1_qest_q  <= coord_recip[47:32];
      s1_prod_q  <= PW'(s0_offset_q) * PW'(s0_fh_q);
      s1_h_q     <= s0_h_q;
      s1_fh_q    <= s0_fh_q;
    end
  end

  // Tile remainder: the quotient estimate is at most one short, so one correction.
  logic [24:0] tile_mul;
  logic [15:0] tile_rem;
  logic [15:0] tile_rem_fix;
  side_t       s1_side_fix;

  always_comb begin
    tile_mul = 25'(s1_qest_q) * 25'(TileSz);
    tile_rem = s1_coord_q - tile_mul[15:0];
    tile_rem_fix = (tile_rem >= 16'(TileSz)) ? tile_rem - 16'(TileSz) : tile_rem;
    s1_side_fix = s1_side_q;
    s1_side_fix.texel_x = tile_rem_fix[5:0];
  end

  // Restoring divide by the wall height, one quotient bit per stage, MSB first.
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic                v_src;
    logic [PW-1:0]       rem_src;
    logic [QW-1:0]       quo_src;
    logic [15:0]         h_src;
    logic [FACE_H_W-1:0] fh_src;
    side_t               side_src;
    logic [PW-1:0]       trial;
    logic                take;

    if (j == 0) begin : g_first
      assign v_src    = s1_v_q;
      assign rem_src  = s1_prod_q;
      assign quo_src  = '0;
      assign h_src    = s1_h_q;
      assign fh_src   = s1_fh_q;
      assign side_src = s1_side_fix;
    end else begin : g_next
      assign v_src    = d_v_q[j-1];
      assign rem_src  = d_rem_q[j-1];
      assign quo_src  = d_quo_q[j-1];
      assign h_src    = d_h_q[j-1];
      assign fh_src   = d_fh_q[j-1];
      assign side_src = d_side_q[j-1];
    end

    assign trial = PW'(h_src) << (QW - 1 - j);
    assign take  = rem_src >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v_q[j] <= 1'b0;
      end else if (en_d[j]) begin
        d_v_q[j] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_d[j] && v_src) begin
        d_rem_q[j]  <= take ? rem_src - trial : rem_src;
        d_quo_q[j]  <= quo_src | (QW'(take) << (QW - 1 - j));
        d_h_q[j]    <= h_src;
        d_fh_q[j]   <= fh_src;
        d_side_q[j] <= side_src;
      end
    end
  end

  // Output stage: clamp the texel row to the face and to the field range.
  logic [QW-1:0]       quo_last;
  logic [FACE_H_W-1:0] fh_last;
  logic [QW-1:0]       ty_face;
  logic [9:0]          ty_out;
  out_item_t           out_d;

  always_comb begin
    quo_last = d_quo_q[QW-1];
    fh_last  = d_fh_q[QW-1];
    if (fh_last == '0) begin
      ty_face = '0;
    end else if (quo_last >= fh_last) begin
      ty_face = fh_last - QW'(1);
    end else begin
      ty_face = quo_last;
    end
    ty_out = (ty_face > QW'(1023)) ? 10'd1023 : ty_face[9:0];
    out_d.screen_x = d_side_q[QW-1].screen_x;
    out_d.screen_y = d_side_q[QW-1].screen_y;
    out_d.face     = d_side_q[QW-1].face;
    out_d.texel_x  = d_side_q[QW-1].texel_x;
    out_d.texel_y  = ty_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= d_v_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && d_v_q[QW-1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // A kept item always lies inside the span, so its offset is below the height.
  a_offset_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_v_q |-> (s0_offset_q < s0_h_q))
    else $error("row offset outside the wall span");

  // The texel row never reaches the height of its face when that height is nonzero.
  a_texel_y_in_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && face_rows_q[out_q.face] != '0) |->
      (11'(out_q.texel_y) < face_rows_q[out_q.face]))
    else $error("texel row beyond face height");

  // The texel column stays inside one tile.
  a_texel_x_in_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ((TILE_SIZE > 64) || (32'(out_q.texel_x) < TILE_SIZE)))
    else $error("texel column beyond tile size");

  // A result advances whenever the output is not stalled.
  a_out_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_stall_i && !d_v_q[QW-1]) |=> !out_v_q)
    else $error("output transfer did not retire the result");

endmodule

`default_nettype wire

/* test/wall_texel_coordinate_mapper_test.sv */
`timescale 1ns / 1ps

module wall_texel_coordinate_mapper_test;
  import wtcm_pkg::*;

  localparam int unsigned SCREEN_ROWS = DEF_SCREEN_ROWS;
  localparam int unsigned TILE_SIZE   = DEF_TILE_SIZE;
  localparam int unsigned STRIP_WIDTH = DEF_STRIP_WIDTH;
  localparam int unsigned CENTER_ROW  = SCREEN_ROWS / 2;

  // Run control: the pipeline is 14 deep, and the drain wait covers anything in flight.
  localparam int unsigned DRAIN_CYCLES     = 20;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned LONG_HOLD_AT     = 300;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  // Keeps its own copy of the face heights and predicts one texel coordinate per kept request.
  class texel_scoreboard;
    out_item_t pending[$];
    logic [FACE_H_W-1:0] face_rows [4];
    int unsigned mismatches;

    function new();
      foreach (face_rows[i]) face_rows[i] = FACE_H_RESET;
      mismatches = 0;
    endfunction

    // Returns 1 and fills res when the request lands inside the wall span and the strip.
    function bit map_pixel(input in_item_t req, output out_item_t res);
      int unsigned half;
      int unsigned top;
      int unsigned bottom;
      longint unsigned offset;
      longint unsigned scaled;
      logic [FACE_H_W-1:0] fh;
      face_e f;
      res = '0;
      if (req.sub_column >= STRIP_WIDTH) return 1'b0;
      half = req.wall_height / 2;
      top = (half >= CENTER_ROW) ? 0 : CENTER_ROW - half;
      bottom = (CENTER_ROW + half > SCREEN_ROWS) ? SCREEN_ROWS : CENTER_ROW + half;
      if (req.row < top || req.row >= bottom) return 1'b0;

      // Face from the angle quadrant and the orientation of the grid line.
      if (req.hit_vertical) begin
        f = (req.view_angle < QUARTER_TURN || req.view_angle > THREE_QUARTER_TURN) ?
            FACE_EAST : FACE_WEST;
      end else begin
        f = (req.view_angle != '0 && req.view_angle < HALF_TURN) ? FACE_SOUTH : FACE_NORTH;
      end

      // Texture row: offset into the span scaled to the face height, then clamped.
      fh = face_rows[f];
      if (fh == '0) begin
        scaled = 0;
      end else begin
        offset = req.row;
        offset = offset + half - CENTER_ROW;
        scaled = (offset * fh) / req.wall_height;
        if (scaled >= fh) scaled = fh - 1;
        if (scaled > 1023) scaled = 1023;
      end

      res.screen_x = 14'(int'(req.column_index) * STRIP_WIDTH + req.sub_column);
      res.screen_y = req.row;
      res.face     = f;
      res.texel_x  = 6'((req.hit_vertical ? req.hit_y : req.hit_x) % TILE_SIZE);
      res.texel_y  = 10'(scaled);
      return 1'b1;
    endfunction

    // Called for every accepted request; returns 1 when it is expected to produce a result.
    function bit note_request(input in_item_t req);
      out_item_t res;
      if (!map_pixel(req, res)) return 1'b0;
      pending.push_back(res);
      return 1'b1;
    endfunction

    // Compares one output transfer against the oldest prediction.
    function void check_texel(input out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected texel sx=%0d sy=%0d face=%0d tx=%0d ty=%0d", $time,
                   got.screen_x, got.screen_y, got.face, got.texel_x, got.texel_y);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
          got.face !== want.face || got.texel_x !== want.texel_x ||
          got.texel_y !== want.texel_y) begin
        if (mismatches < 10) begin
          $display("%0t: texel mismatch, expected sx=%0d sy=%0d face=%0d tx=%0d ty=%0d",
                   $time, want.screen_x, want.screen_y, want.face, want.texel_x,
                   want.texel_y);
          $display("%0t:                   actual sx=%0d sy=%0d face=%0d tx=%0d ty=%0d",
                   $time, got.screen_x, got.screen_y, got.face, got.texel_x, got.texel_y);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [FACE_H_W-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_item_o;

  texel_scoreboard scoreboard = new();
  bit no_idle = 1'b0;
  int unsigned cycle_count = 0;

  wall_texel_coordinate_mapper #(
    .SCREEN_ROWS(SCREEN_ROWS),
    .TILE_SIZE  (TILE_SIZE),
    .STRIP_WIDTH(STRIP_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total cycle count.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("wall_texel_coordinate_mapper_test: done, errors");
    $finish;
  end

  // Output side: checks each transfer, then draws a stall; one long hold fills the pipe.
  initial begin
    int unsigned stall_left;
    int unsigned results;
    stall_left = 0;
    results = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        scoreboard.check_texel(out_item_o);
        results++;
        if (results == LONG_HOLD_AT) stall_left = LONG_HOLD_CYCLES;
        else stall_left = no_idle ? 0 : $urandom_range(0, 14);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offers one request until it transfers, then, unless fast, idles for a random gap.
  task automatic send_request(input in_item_t req, input bit fast, output bit yields);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    yields = scoreboard.note_request(req);
    gap = fast ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_pixel(input logic [15:0] angle, input logic vertical,
                            input logic [15:0] hx, input logic [15:0] hy,
                            input logic [15:0] h, input logic [9:0] col,
                            input logic [3:0] sub, input logic [9:0] row);
    in_item_t req;
    bit yields;
    req.view_angle   = angle;
    req.hit_vertical = vertical;
    req.hit_x        = hx;
    req.hit_y        = hy;
    req.wall_height  = h;
    req.column_index = col;
    req.sub_column   = sub;
    req.row          = row;
    send_request(req, 1'b0, yields);
  endtask

  // Waits until every predicted texel has arrived and the pipeline has emptied.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (scoreboard.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the write enable after the last one.
  task automatic write_face_height(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [FACE_H_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    scoreboard.face_rows[idx] = value;
  endtask

  task automatic configure(input logic [FACE_H_W-1:0] east, input logic [FACE_H_W-1:0] west,
                           input logic [FACE_H_W-1:0] south,
                           input logic [FACE_H_W-1:0] north);
    write_face_height(REG_EAST_FACE_HEIGHT, east);
    write_face_height(REG_WEST_FACE_HEIGHT, west);
    write_face_height(REG_SOUTH_FACE_HEIGHT, south);
    write_face_height(REG_NORTH_FACE_HEIGHT, north);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly in-span requests with random content, plus malformed strips and stray rows.
  task automatic run_random(input int unsigned count, input bit fast);
    in_item_t req;
    bit yields;
    int unsigned sent;
    int unsigned kind;
    int unsigned half;
    int unsigned top;
    int unsigned bottom;
    logic [15:0] landmark;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);

      // Angles cluster around the quadrant edges now and then.
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: landmark = '0;
          1: landmark = QUARTER_TURN;
          2: landmark = HALF_TURN;
          default: landmark = THREE_QUARTER_TURN;
        endcase
        req.view_angle = landmark + 16'($urandom_range(0, 4)) - 16'd2;
      end else begin
        req.view_angle = 16'($urandom);
      end
      req.hit_vertical = 1'($urandom);
      req.hit_x        = 16'($urandom);
      req.hit_y        = 16'($urandom);
      req.column_index = 10'($urandom);

      case ($urandom_range(0, 9))
        0: req.wall_height = 16'($urandom);
        1: req.wall_height = 16'($urandom_range(2, 8));
        default: req.wall_height = 16'($urandom_range(2, 600));
      endcase

      if (kind < 8) begin
        if (req.wall_height < 2) req.wall_height = 16'd2;
        half = req.wall_height / 2;
        top = (half >= CENTER_ROW) ? 0 : CENTER_ROW - half;
        bottom = (CENTER_ROW + half > SCREEN_ROWS) ? SCREEN_ROWS : CENTER_ROW + half;
        req.sub_column = '0;
        req.row = 10'($urandom_range(top, bottom - 1));
      end else if (kind == 8) begin
        req.sub_column = 4'($urandom);
        req.row = 10'($urandom_range(0, SCREEN_ROWS - 1));
      end else begin
        req.wall_height = 16'($urandom);
        req.sub_column = 4'($urandom);
        req.row = 10'($urandom);
      end

      send_request(req, fast, yields);
      sent++;
    end
  endtask

  // Main sequence: reset, directed corners, then random phases under several settings.
  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_EAST_FACE_HEIGHT;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Face selection on both sides of every quadrant edge, at reset heights.
    send_pixel(16'd0,     1'b0, 16'd5, 16'd7, 16'd100, 10'd0, 4'd0, 10'd256);
    send_pixel(16'd1,     1'b0, 16'd5, 16'd7, 16'd100, 10'd1, 4'd0, 10'd256);
    send_pixel(16'd32767, 1'b0, 16'd5, 16'd7, 16'd100, 10'd2, 4'd0, 10'd256);
    send_pixel(16'd32768, 1'b0, 16'd5, 16'd7, 16'd100, 10'd3, 4'd0, 10'd256);
    send_pixel(16'd65535, 1'b0, 16'd5, 16'd7, 16'd100, 10'd4, 4'd0, 10'd256);
    send_pixel(16'd0,     1'b1, 16'd5, 16'd7, 16'd100, 10'd5, 4'd0, 10'd256);
    send_pixel(16'd16383, 1'b1, 16'd5, 16'd7, 16'd100, 10'd6, 4'd0, 10'd256);
    send_pixel(16'd16384, 1'b1, 16'd5, 16'd7, 16'd100, 10'd7, 4'd0, 10'd256);
    send_pixel(16'd49152, 1'b1, 16'd5, 16'd7, 16'd100, 10'd8, 4'd0, 10'd256);
    send_pixel(16'd49153, 1'b1, 16'd5, 16'd7, 16'd100, 10'd9, 4'd0, 10'd256);

    // An empty span: zero height and a height of one row.
    send_pixel(16'd100, 1'b0, 16'd5, 16'd7, 16'd0, 10'd10, 4'd0, 10'd256);
    send_pixel(16'd100, 1'b0, 16'd5, 16'd7, 16'd1, 10'd11, 4'd0, 10'd256);

    // The tallest wall is clamped to the screen; extreme coordinates and columns.
    send_pixel(16'd100,   1'b0, 16'hFFFF, 16'd0, 16'hFFFF, 10'd1023, 4'd0, 10'd0);
    send_pixel(16'd40000, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 10'd1023, 4'd0, 10'd511);
    send_pixel(16'd100,   1'b0, 16'd5, 16'd7, 16'hFFFF, 10'd12, 4'd0, 10'd1023);

    // Span edges: top row included, bottom row excluded.
    send_pixel(16'd100, 1'b0, 16'd63, 16'd7, 16'd100, 10'd13, 4'd0, 10'd206);
    send_pixel(16'd100, 1'b0, 16'd64, 16'd7, 16'd100, 10'd14, 4'd0, 10'd305);
    send_pixel(16'd100, 1'b0, 16'd65, 16'd7, 16'd100, 10'd15, 4'd0, 10'd306);
    send_pixel(16'd100, 1'b0, 16'd5, 16'd7, 16'd101, 10'd16, 4'd0, 10'd205);

    // A sub-column outside the strip is dropped.
    send_pixel(16'd100, 1'b0, 16'd5, 16'd7, 16'd100, 10'd17, 4'd15, 10'd256);

    // Short walls where the division truncates.
    send_pixel(16'd100, 1'b0, 16'd5, 16'd7, 16'd2, 10'd18, 4'd0, 10'd255);
    send_pixel(16'd100, 1'b0, 16'd5, 16'd7, 16'd2, 10'd19, 4'd0, 10'd256);
    send_pixel(16'd100, 1'b0, 16'd5, 16'd7, 16'd3, 10'd20, 4'd0, 10'd256);

    run_random(250, 1'b0);
    wait_idle();

    // Zero height, saturating height, single row and the largest legal height.
    configure(11'd0, 11'd2047, 11'd1, 11'd1024);
    run_random(200, 1'b0);
    wait_idle();

    // Same extremes on the other faces, with both sides running without gaps.
    no_idle = 1'b1;
    configure(11'd1024, 11'd1, 11'd2047, 11'd0);
    run_random(200, 1'b1);
    wait_idle();
    no_idle = 1'b0;

    repeat (4) begin
      configure(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
                11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
      run_random(250, 1'b0);
      wait_idle();
    end

    if (scoreboard.mismatches == 0 && scoreboard.pending.size() == 0) begin
      $display("wall_texel_coordinate_mapper_test: done, clean");
    end else begin
      $display("wall_texel_coordinate_mapper_test: done, errors");
    end
    $finish;
  end

endmodule
